// ===== design/lid_pkg.sv =====
`timescale 1ns / 1ps

package lid_pkg;

    localparam int CoordW     = 24;
    localparam int DiffW      = CoordW + 1;
    localparam int ProdW      = 2 * CoordW;
    localparam int CrossW     = ProdW + 1;
    localparam int DetProdW   = 2 * DiffW;
    localparam int DetW       = DetProdW + 1;
    localparam int SplitW     = 24;
    localparam int PartW      = 2 * DiffW;
    localparam int NumW       = 75;
    localparam int QuoW       = 32;
    localparam int CmpW       = DetW + QuoW;
    localparam int DivStages  = QuoW;
    localparam int DivLat     = DivStages + 1;
    localparam int ExW        = QuoW + 1;
    localparam int HalfW      = 16;
    localparam int HiW        = ExW - HalfW;
    localparam int SqW        = 64;
    localparam int SqrtStages = SqW / 2;
    localparam int OutW       = 32;

    localparam logic [QuoW-1:0] SatPos  = 32'h7FFF_FFFF;
    localparam logic [QuoW-1:0] SatNeg  = 32'h8000_0000;
    localparam logic [OutW-1:0] DistMax = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [CoordW-1:0] line_a_start_x;
        logic signed [CoordW-1:0] line_a_start_y;
        logic signed [CoordW-1:0] line_a_end_x;
        logic signed [CoordW-1:0] line_a_end_y;
        logic signed [CoordW-1:0] line_b_start_x;
        logic signed [CoordW-1:0] line_b_start_y;
        logic signed [CoordW-1:0] line_b_end_x;
        logic signed [CoordW-1:0] line_b_end_y;
        logic signed [CoordW-1:0] probe_x;
        logic signed [CoordW-1:0] probe_y;
    } lid_in_t;

    typedef struct packed {
        logic signed [OutW-1:0] cross_x;
        logic signed [OutW-1:0] cross_y;
        logic        [OutW-1:0] distance;
        logic                   parallel;
        logic                   clipped;
    } lid_out_t;

endpackage

// ===== design/lid_div.sv =====
`timescale 1ns / 1ps

module lid_div (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic        [lid_pkg::NumW-1:0]      num_mag,
    input  logic        [lid_pkg::DetW-1:0]      den,
    input  logic                                 neg,
    input  logic                                 ovf,
    output logic signed [lid_pkg::QuoW-1:0]      quo,
    output logic                                 sat
);

    localparam int NumW      = lid_pkg::NumW;
    localparam int DetW      = lid_pkg::DetW;
    localparam int QuoW      = lid_pkg::QuoW;
    localparam int CmpW      = lid_pkg::CmpW;
    localparam int DivStages = lid_pkg::DivStages;

    logic [NumW-1:0] rem_reg [1:DivStages];
    logic [QuoW-1:0] q_reg   [1:DivStages];
    logic [DetW-1:0] den_reg [1:DivStages];
    logic            neg_reg [1:DivStages];
    logic            ovf_reg [1:DivStages];

    logic [NumW-1:0] rem_cur [0:DivStages-1];
    logic [QuoW-1:0] q_cur   [0:DivStages-1];
    logic [DetW-1:0] den_cur [0:DivStages-1];
    logic            neg_cur [0:DivStages-1];
    logic            ovf_cur [0:DivStages-1];

    logic signed [QuoW-1:0] quo_reg;
    logic                   sat_reg;

    for (genvar k = 0; k < DivStages; k++) begin : g_stage
        localparam int Sh = QuoW - 1 - k;
        logic [CmpW-1:0] trial;
        logic            take;

        if (k == 0) begin : g_first
            assign rem_cur[k] = num_mag;
            assign q_cur[k]   = '0;
            assign den_cur[k] = den;
            assign neg_cur[k] = neg;
            assign ovf_cur[k] = ovf;
        end else begin : g_next
            assign rem_cur[k] = rem_reg[k];
            assign q_cur[k]   = q_reg[k];
            assign den_cur[k] = den_reg[k];
            assign neg_cur[k] = neg_reg[k];
            assign ovf_cur[k] = ovf_reg[k];
        end

        assign trial = CmpW'(den_cur[k]) << Sh;
        assign take  = CmpW'(rem_cur[k]) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? NumW'(CmpW'(rem_cur[k]) - trial) : rem_cur[k];
                q_reg[k+1]   <= {q_cur[k][QuoW-2:0], take};
                den_reg[k+1] <= den_cur[k];
                neg_reg[k+1] <= neg_cur[k];
                ovf_reg[k+1] <= ovf_cur[k];
            end
        end
    end

    logic [QuoW-1:0] limit;
    logic            over;

    assign limit = neg_reg[DivStages] ? lid_pkg::SatNeg : lid_pkg::SatPos;
    assign over  = ovf_reg[DivStages] || (q_reg[DivStages] > limit);

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg <= over;
            if (over) begin
                quo_reg <= limit;
            end else if (neg_reg[DivStages]) begin
                quo_reg <= -q_reg[DivStages];
            end else begin
                quo_reg <= q_reg[DivStages];
            end
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

// ===== design/line_intersection_distance.sv =====
`timescale 1ns / 1ps

// line intersection and distance to a probe point
// s_ channel: one request holds two lines (two points each) and a probe point,
//   all signed Q15.8; taken when s_valid and s_ready are both high
// m_ channel: one result per request, in request order: intersection x/y
//   (Q23.8, saturated), distance (unsigned Q24.8, floored root, saturated),
//   parallel when the determinant is zero (other fields zero), clipped on
//   any saturation
// pipeline: 7 setup stages, 33-stage restoring divider, 5 square/sum
//   stages, 32-stage root, output register
// throughput: one request per cycle while s_ready is high; every stage is a
//   plain register, the divider and root retire one bit per stage
// stall: a skid register behind the output register takes one more result;
//   s_ready drops only while that skid register is full, and the whole
//   pipeline then holds
// reset: aresetn clears every valid bit (output and skid too), no data
module line_intersection_distance (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lid_pkg::lid_in_t   s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output lid_pkg::lid_out_t  m_payload
);

    localparam int CoordW     = lid_pkg::CoordW;
    localparam int DiffW      = lid_pkg::DiffW;
    localparam int ProdW      = lid_pkg::ProdW;
    localparam int CrossW     = lid_pkg::CrossW;
    localparam int DetProdW   = lid_pkg::DetProdW;
    localparam int DetW       = lid_pkg::DetW;
    localparam int SplitW     = lid_pkg::SplitW;
    localparam int PartW      = lid_pkg::PartW;
    localparam int NumW       = lid_pkg::NumW;
    localparam int QuoW       = lid_pkg::QuoW;
    localparam int CmpW       = lid_pkg::CmpW;
    localparam int DivLat     = lid_pkg::DivLat;
    localparam int ExW        = lid_pkg::ExW;
    localparam int HalfW      = lid_pkg::HalfW;
    localparam int HiW        = lid_pkg::HiW;
    localparam int SqW        = lid_pkg::SqW;
    localparam int SqrtStages = lid_pkg::SqrtStages;
    localparam int OutW       = lid_pkg::OutW;
    localparam int FrontLen   = 7;
    localparam int BackLen    = 5;

    typedef struct packed {
        logic                     zero;
        logic signed [CoordW-1:0] px;
        logic signed [CoordW-1:0] py;
    } lid_dside_t;

    typedef struct packed {
        logic                   zero;
        logic                   sat;
        logic                   ovf;
        logic signed [QuoW-1:0] cx;
        logic signed [QuoW-1:0] cy;
    } lid_rside_t;

    logic en;
    logic skid_valid_reg;
    logic m_valid_reg;
    lid_pkg::lid_out_t m_data_reg;
    lid_pkg::lid_out_t skid_data_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // front valid chain
    logic fv_reg [1:FrontLen];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= FrontLen; k++) begin
                fv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            fv_reg[1] <= s_valid;
            for (int k = 2; k <= FrontLen; k++) begin
                fv_reg[k] <= fv_reg[k-1];
            end
        end
    end

    // stage 1: direction vectors and products of point coordinates
    logic signed [DiffW-1:0]  dxa1_reg, dya1_reg, dxb1_reg, dyb1_reg;
    logic signed [ProdW-1:0]  ma1_reg, ma2_reg, mb1_reg, mb2_reg;
    logic signed [CoordW-1:0] px1_reg, py1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dxa1_reg <= DiffW'(s_payload.line_a_start_x) - DiffW'(s_payload.line_a_end_x);
            dya1_reg <= DiffW'(s_payload.line_a_start_y) - DiffW'(s_payload.line_a_end_y);
            dxb1_reg <= DiffW'(s_payload.line_b_start_x) - DiffW'(s_payload.line_b_end_x);
            dyb1_reg <= DiffW'(s_payload.line_b_start_y) - DiffW'(s_payload.line_b_end_y);
            ma1_reg  <= ProdW'(s_payload.line_a_start_x) * ProdW'(s_payload.line_a_end_y);
            ma2_reg  <= ProdW'(s_payload.line_a_start_y) * ProdW'(s_payload.line_a_end_x);
            mb1_reg  <= ProdW'(s_payload.line_b_start_x) * ProdW'(s_payload.line_b_end_y);
            mb2_reg  <= ProdW'(s_payload.line_b_start_y) * ProdW'(s_payload.line_b_end_x);
            px1_reg  <= s_payload.probe_x;
            py1_reg  <= s_payload.probe_y;
        end
    end

    // stage 2: line constants and determinant products
    logic signed [CrossW-1:0]   ca2_reg, cb2_reg;
    logic signed [DetProdW-1:0] dp1_reg, dp2_reg;
    logic signed [DiffW-1:0]    dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg;
    logic signed [CoordW-1:0]   px2_reg, py2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ca2_reg  <= CrossW'(ma1_reg) - CrossW'(ma2_reg);
            cb2_reg  <= CrossW'(mb1_reg) - CrossW'(mb2_reg);
            dp1_reg  <= DetProdW'(dxa1_reg) * DetProdW'(dyb1_reg);
            dp2_reg  <= DetProdW'(dya1_reg) * DetProdW'(dxb1_reg);
            dxa2_reg <= dxa1_reg;
            dya2_reg <= dya1_reg;
            dxb2_reg <= dxb1_reg;
            dyb2_reg <= dyb1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
        end
    end

    // stage 3: determinant and split partial products of the numerators
    logic signed [DiffW-1:0] ca_lo, ca_hi, cb_lo, cb_hi;

    assign ca_lo = $signed({1'b0, ca2_reg[SplitW-1:0]});
    assign ca_hi = $signed(ca2_reg[CrossW-1:SplitW]);
    assign cb_lo = $signed({1'b0, cb2_reg[SplitW-1:0]});
    assign cb_hi = $signed(cb2_reg[CrossW-1:SplitW]);

    logic signed [DetW-1:0]   det3_reg;
    logic signed [PartW-1:0]  xa_lo3_reg, xa_hi3_reg, xb_lo3_reg, xb_hi3_reg;
    logic signed [PartW-1:0]  ya_lo3_reg, ya_hi3_reg, yb_lo3_reg, yb_hi3_reg;
    logic signed [CoordW-1:0] px3_reg, py3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            det3_reg   <= DetW'(dp1_reg) - DetW'(dp2_reg);
            xa_lo3_reg <= PartW'(ca_lo) * PartW'(dxb2_reg);
            xa_hi3_reg <= PartW'(ca_hi) * PartW'(dxb2_reg);
            xb_lo3_reg <= PartW'(cb_lo) * PartW'(dxa2_reg);
            xb_hi3_reg <= PartW'(cb_hi) * PartW'(dxa2_reg);
            ya_lo3_reg <= PartW'(ca_lo) * PartW'(dyb2_reg);
            ya_hi3_reg <= PartW'(ca_hi) * PartW'(dyb2_reg);
            yb_lo3_reg <= PartW'(cb_lo) * PartW'(dya2_reg);
            yb_hi3_reg <= PartW'(cb_hi) * PartW'(dya2_reg);
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
        end
    end

    // stage 4: recombine partial products
    logic signed [NumW-1:0]   tx1_4_reg, tx2_4_reg, ty1_4_reg, ty2_4_reg;
    logic signed [DetW-1:0]   det4_reg;
    logic signed [CoordW-1:0] px4_reg, py4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tx1_4_reg <= (NumW'(xa_hi3_reg) <<< SplitW) + NumW'(xa_lo3_reg);
            tx2_4_reg <= (NumW'(xb_hi3_reg) <<< SplitW) + NumW'(xb_lo3_reg);
            ty1_4_reg <= (NumW'(ya_hi3_reg) <<< SplitW) + NumW'(ya_lo3_reg);
            ty2_4_reg <= (NumW'(yb_hi3_reg) <<< SplitW) + NumW'(yb_lo3_reg);
            det4_reg  <= det3_reg;
            px4_reg   <= px3_reg;
            py4_reg   <= py3_reg;
        end
    end

    // stage 5: numerators, determinant magnitude
    logic signed [NumW-1:0]   numx5_reg, numy5_reg;
    logic        [DetW-1:0]   dmag5_reg;
    logic                     dneg5_reg, zero5_reg;
    logic signed [CoordW-1:0] px5_reg, py5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            numx5_reg <= tx1_4_reg - tx2_4_reg;
            numy5_reg <= ty1_4_reg - ty2_4_reg;
            dmag5_reg <= det4_reg[DetW-1] ? DetW'(-det4_reg) : DetW'(det4_reg);
            dneg5_reg <= det4_reg[DetW-1];
            zero5_reg <= (det4_reg == '0);
            px5_reg   <= px4_reg;
            py5_reg   <= py4_reg;
        end
    end

    // stage 6: numerator magnitudes and quotient signs
    logic        [NumW-1:0]   nx6_reg, ny6_reg;
    logic                     negx6_reg, negy6_reg, zero6_reg;
    logic        [DetW-1:0]   dmag6_reg;
    logic signed [CoordW-1:0] px6_reg, py6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx6_reg   <= numx5_reg[NumW-1] ? NumW'(-numx5_reg) : NumW'(numx5_reg);
            ny6_reg   <= numy5_reg[NumW-1] ? NumW'(-numy5_reg) : NumW'(numy5_reg);
            negx6_reg <= numx5_reg[NumW-1] ^ dneg5_reg;
            negy6_reg <= numy5_reg[NumW-1] ^ dneg5_reg;
            zero6_reg <= zero5_reg;
            dmag6_reg <= dmag5_reg;
            px6_reg   <= px5_reg;
            py6_reg   <= py5_reg;
        end
    end

    // stage 7: quotient overflow check
    logic        [NumW-1:0]   nx7_reg, ny7_reg;
    logic                     negx7_reg, negy7_reg, ovfx7_reg, ovfy7_reg;
    logic        [DetW-1:0]   dmag7_reg;
    lid_dside_t               ds7_reg;
    logic        [CmpW-1:0]   den_top;

    assign den_top = {dmag6_reg, {QuoW{1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            nx7_reg   <= nx6_reg;
            ny7_reg   <= ny6_reg;
            negx7_reg <= negx6_reg;
            negy7_reg <= negy6_reg;
            ovfx7_reg <= CmpW'(nx6_reg) >= den_top;
            ovfy7_reg <= CmpW'(ny6_reg) >= den_top;
            dmag7_reg <= dmag6_reg;
            ds7_reg   <= '{zero: zero6_reg, px: px6_reg, py: py6_reg};
        end
    end

    // dividers
    logic signed [QuoW-1:0] cx_div, cy_div;
    logic                   satx_div, saty_div;

    lid_div u_div_x (
        .aclk    (aclk),
        .en      (en),
        .num_mag (nx7_reg),
        .den     (dmag7_reg),
        .neg     (negx7_reg),
        .ovf     (ovfx7_reg),
        .quo     (cx_div),
        .sat     (satx_div)
    );

    lid_div u_div_y (
        .aclk    (aclk),
        .en      (en),
        .num_mag (ny7_reg),
        .den     (dmag7_reg),
        .neg     (negy7_reg),
        .ovf     (ovfy7_reg),
        .quo     (cy_div),
        .sat     (saty_div)
    );

    logic       dv_reg [1:DivLat];
    lid_dside_t ds_reg [1:DivLat];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= DivLat; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dv_reg[1] <= fv_reg[FrontLen];
            for (int k = 2; k <= DivLat; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ds_reg[1] <= ds7_reg;
            for (int k = 2; k <= DivLat; k++) begin
                ds_reg[k] <= ds_reg[k-1];
            end
        end
    end

    // back valid chain
    logic bv_reg [1:BackLen];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= BackLen; k++) begin
                bv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            bv_reg[1] <= dv_reg[DivLat];
            for (int k = 2; k <= BackLen; k++) begin
                bv_reg[k] <= bv_reg[k-1];
            end
        end
    end

    // back stage 1: offsets to the probe
    logic signed [ExW-1:0]  ex1_reg, ey1_reg;
    logic signed [QuoW-1:0] cx1_reg, cy1_reg;
    logic                   sat1_reg, zero1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ex1_reg   <= ExW'(cx_div) - ExW'(ds_reg[DivLat].px);
            ey1_reg   <= ExW'(cy_div) - ExW'(ds_reg[DivLat].py);
            cx1_reg   <= cx_div;
            cy1_reg   <= cy_div;
            sat1_reg  <= satx_div | saty_div;
            zero1_reg <= ds_reg[DivLat].zero;
        end
    end

    // back stage 2: offset magnitudes
    logic        [ExW-1:0]  mx2_reg, my2_reg;
    logic signed [QuoW-1:0] cx2_reg, cy2_reg;
    logic                   sat2_reg, zero2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mx2_reg   <= ex1_reg[ExW-1] ? ExW'(-ex1_reg) : ExW'(ex1_reg);
            my2_reg   <= ey1_reg[ExW-1] ? ExW'(-ey1_reg) : ExW'(ey1_reg);
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            sat2_reg  <= sat1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // back stage 3: split squares
    logic [2*HiW-1:0]       xhh3_reg, yhh3_reg;
    logic [HiW+HalfW-1:0]   xhl3_reg, yhl3_reg;
    logic [2*HalfW-1:0]     xll3_reg, yll3_reg;
    logic signed [QuoW-1:0] cx3_reg, cy3_reg;
    logic                   sat3_reg, zero3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xhh3_reg  <= (2*HiW)'(mx2_reg[ExW-1:HalfW]) * (2*HiW)'(mx2_reg[ExW-1:HalfW]);
            xhl3_reg  <= (HiW+HalfW)'(mx2_reg[ExW-1:HalfW]) * (HiW+HalfW)'(mx2_reg[HalfW-1:0]);
            xll3_reg  <= (2*HalfW)'(mx2_reg[HalfW-1:0]) * (2*HalfW)'(mx2_reg[HalfW-1:0]);
            yhh3_reg  <= (2*HiW)'(my2_reg[ExW-1:HalfW]) * (2*HiW)'(my2_reg[ExW-1:HalfW]);
            yhl3_reg  <= (HiW+HalfW)'(my2_reg[ExW-1:HalfW]) * (HiW+HalfW)'(my2_reg[HalfW-1:0]);
            yll3_reg  <= (2*HalfW)'(my2_reg[HalfW-1:0]) * (2*HalfW)'(my2_reg[HalfW-1:0]);
            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;
            sat3_reg  <= sat2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // back stage 4: squares, wrapped to 64 bits
    logic [SqW-1:0]         sx4_reg, sy4_reg;
    logic signed [QuoW-1:0] cx4_reg, cy4_reg;
    logic                   sat4_reg, zero4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sx4_reg   <= (SqW'(xhh3_reg) << (2*HalfW)) + (SqW'(xhl3_reg) << (HalfW+1))
                         + SqW'(xll3_reg);
            sy4_reg   <= (SqW'(yhh3_reg) << (2*HalfW)) + (SqW'(yhl3_reg) << (HalfW+1))
                         + SqW'(yll3_reg);
            cx4_reg   <= cx3_reg;
            cy4_reg   <= cy3_reg;
            sat4_reg  <= sat3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // back stage 5: sum of squares with carry out
    logic [SqW:0]   sum_w;
    logic [SqW-1:0] sum5_reg;
    lid_rside_t     rs5_reg;

    assign sum_w = {1'b0, sx4_reg} + {1'b0, sy4_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            sum5_reg <= sum_w[SqW-1:0];
            rs5_reg  <= '{zero: zero4_reg, sat: sat4_reg, ovf: sum_w[SqW],
                          cx: cx4_reg, cy: cy4_reg};
        end
    end

    // square root, one result bit per stage
    logic [SqW-1:0] sv_reg [1:SqrtStages];
    logic [SqW-1:0] sr_reg [1:SqrtStages];
    lid_rside_t     rs_reg [1:SqrtStages];
    logic           qv_reg [1:SqrtStages];

    logic [SqW-1:0] sv_cur [0:SqrtStages-1];
    logic [SqW-1:0] sr_cur [0:SqrtStages-1];
    lid_rside_t     rs_cur [0:SqrtStages-1];
    logic           qv_cur [0:SqrtStages-1];

    for (genvar k = 0; k < SqrtStages; k++) begin : g_root
        localparam int Sh = SqW - 2 - 2 * k;
        logic [SqW-1:0] bitc;
        logic [SqW-1:0] trial;
        logic           take;

        if (k == 0) begin : g_first
            assign sv_cur[k] = sum5_reg;
            assign sr_cur[k] = '0;
            assign rs_cur[k] = rs5_reg;
            assign qv_cur[k] = bv_reg[BackLen];
        end else begin : g_next
            assign sv_cur[k] = sv_reg[k];
            assign sr_cur[k] = sr_reg[k];
            assign rs_cur[k] = rs_reg[k];
            assign qv_cur[k] = qv_reg[k];
        end

        assign bitc  = SqW'(1) << Sh;
        assign trial = sr_cur[k] + bitc;
        assign take  = sv_cur[k] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                sv_reg[k+1] <= take ? sv_cur[k] - trial : sv_cur[k];
                sr_reg[k+1] <= take ? (sr_cur[k] >> 1) + bitc : sr_cur[k] >> 1;
                rs_reg[k+1] <= rs_cur[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qv_reg[k+1] <= 1'b0;
            end else if (en) begin
                qv_reg[k+1] <= qv_cur[k];
            end
        end
    end

    // result formatting
    logic              p_valid;
    lid_pkg::lid_out_t p_data;
    lid_rside_t        rs_last;

    assign p_valid = qv_reg[SqrtStages];
    assign rs_last = rs_reg[SqrtStages];

    always_comb begin
        p_data = '0;
        if (rs_last.zero) begin
            p_data.parallel = 1'b1;
        end else begin
            p_data.cross_x  = rs_last.cx;
            p_data.cross_y  = rs_last.cy;
            p_data.distance = rs_last.ovf ? lid_pkg::DistMax
                                          : sr_reg[SqrtStages][OutW-1:0];
            p_data.clipped  = rs_last.sat | rs_last.ovf;
        end
    end

    // output register and skid register
    logic out_load;

    assign out_load = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= p_valid;
            end
        end else if (p_valid && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : p_data;
        end
        if (!out_load && p_valid && en) begin
            skid_data_reg <= p_data;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid register filled without an output stall");

    a_parallel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.parallel) |->
            (m_data_reg.cross_x == '0 && m_data_reg.cross_y == '0 &&
             m_data_reg.distance == '0 && !m_data_reg.clipped))
        else $error("parallel result with nonzero fields");

endmodule
